// File: rtl/rdfr_pkg.sv
// Shared constants, command/status types and state encodings for Rabin decryption.
package rdfr_pkg;

  localparam int PRIME_BITS = 16;
  localparam int WORD_BITS  = 2 * PRIME_BITS;
  localparam int CNT_W      = $clog2(WORD_BITS + 1);
  localparam int COEF_BITS  = PRIME_BITS + 2;
  localparam int ROUND_W    = $clog2(PRIME_BITS);

  localparam logic [0:0] CFG_PRIME_P = 1'b0;
  localparam logic [0:0] CFG_PRIME_Q = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED,
    OP_PINIT,
    OP_PMUL,
    OP_PSQR,
    OP_EINIT,
    OP_EDIV,
    OP_EUPD,
    OP_YMUL,
    OP_YRED,
    OP_TMUL,
    OP_FIN1,
    OP_FIN2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_PINIT,
    ST_PMUL,
    ST_PSQR,
    ST_EINIT,
    ST_ECHK,
    ST_EDIV,
    ST_EUPD,
    ST_YMUL,
    ST_YRED,
    ST_TMUL,
    ST_FIN1,
    ST_FIN2
  } state_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic zero_prime;
    logic last_round;
    logic eu_done;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/rdfr_modmul.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
module rdfr_modmul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rdfr_pkg::WORD_BITS-1:0] a,
  input  logic [rdfr_pkg::WORD_BITS-1:0] b,
  input  logic [rdfr_pkg::WORD_BITS-1:0] m,
  input  logic [rdfr_pkg::CNT_W-1:0]     nbits,
  output logic                          done,
  output logic [rdfr_pkg::WORD_BITS-1:0] result
);
  import rdfr_pkg::*;

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] b_r, a_r, m_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic [WORD_BITS:0]   t0, t1, t2, t3, mx;

  // a must not exceed m, so each partial sum stays below 2m
  always_comb begin
    mx = {1'b0, m_r};
    t0 = {acc_r, 1'b0};
    t1 = (t0 >= mx) ? t0 - mx : t0;
    t2 = t1 + (b_r[WORD_BITS-1] ? {1'b0, a_r} : '0);
    t3 = (t2 >= mx) ? t2 - mx : t2;
    acc_nxt = t3[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
      cnt_r <= nbits;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[WORD_BITS-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// File: rtl/rdfr_ctrl.sv
// Sequencer for the decryption steps: reduce, exponentiate, Euclid, CRT combine.
module rdfr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rdfr_pkg::stat_t stat,
  output rdfr_pkg::cmd_t  cmd
);
  import rdfr_pkg::*;

  state_t state_r, state_nxt;
  logic   waiting_r, waiting_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      waiting_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      waiting_r <= waiting_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.go    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = OP_LOAD;
        cmd.go   = in_valid;
        if (in_valid) state_nxt = stat.zero_prime ? ST_FIN2 : ST_RED;
      end
      ST_RED: begin
        cmd.op = OP_RED;
        if (stat.done) state_nxt = ST_PINIT;
      end
      ST_PINIT: begin
        cmd.op = OP_PINIT;
        if (stat.done) state_nxt = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.op = OP_PMUL;
        if (stat.done) state_nxt = ST_PSQR;
      end
      ST_PSQR: begin
        cmd.op = OP_PSQR;
        if (stat.done) state_nxt = stat.last_round ? ST_EINIT : ST_PMUL;
      end
      ST_EINIT: begin
        cmd.op = OP_EINIT;
        if (stat.done) state_nxt = ST_ECHK;
      end
      ST_ECHK: begin
        state_nxt = stat.eu_done ? ST_YMUL : ST_EDIV;
      end
      ST_EDIV: begin
        cmd.op = OP_EDIV;
        if (stat.done) state_nxt = ST_EUPD;
      end
      ST_EUPD: begin
        cmd.op = OP_EUPD;
        if (stat.done) state_nxt = ST_ECHK;
      end
      ST_YMUL: begin
        cmd.op = OP_YMUL;
        if (stat.done) state_nxt = ST_YRED;
      end
      ST_YRED: begin
        cmd.op = OP_YRED;
        if (stat.done) state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        cmd.op = OP_TMUL;
        if (stat.done) state_nxt = ST_FIN1;
      end
      ST_FIN1: begin
        cmd.op = OP_FIN1;
        if (stat.done) state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.op = OP_FIN2;
        if (stat.done) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (state_r != ST_IDLE) begin
      // issue once (FIN2 only when the output register is free), then hold until the datapath reports done
      cmd.go = (cmd.op != OP_NONE) && !waiting_r &&
               ((cmd.op != OP_FIN2) || stat.out_free);
    end
    waiting_nxt = stat.done ? 1'b0 : (cmd.go ? 1'b1 : waiting_r);
  end

endmodule

// File: rtl/rdfr_dp.sv
// Datapath: key registers, two modular multiplier lanes, Euclid divider, CRT and output register.
module rdfr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [31:0]         in_ciphertext,
  input  rdfr_pkg::cmd_t      cmd,
  output rdfr_pkg::stat_t     stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [31:0]         out_root_sum,
  output logic [31:0]         out_root_sum_neg,
  output logic [31:0]         out_root_diff,
  output logic [31:0]         out_root_diff_neg
);
  import rdfr_pkg::*;

  logic [PRIME_BITS-1:0] cfg_p_r, cfg_q_r;
  logic [PRIME_BITS-1:0] p_r, q_r, ep_r, eq_r;
  logic [PRIME_BITS-1:0] basep_r, baseq_r, accp_r, accq_r;
  logic [WORD_BITS-1:0]  c_r, n_r, vp_r, vq_r, yp_r, yq_r, t1_r, t2_r, r_r, s_r;
  logic                  zero_r, negp_r, negq_r, out_valid_r;
  logic [ROUND_W-1:0]    round_r;
  logic [PRIME_BITS:0]   psum, qsum;

  // Euclid state
  logic [PRIME_BITS-1:0]        er0_r, er1_r, dquo_r, drem_r;
  logic signed [COEF_BITS-1:0]  es0_r, es1_r, et0_r, et1_r;
  logic [CNT_W-1:0]             dcnt_r;
  logic                         div_busy_r, div_done_r;
  logic [PRIME_BITS:0]          dt;
  logic                         dbit;
  logic signed [PRIME_BITS:0]   qs;
  logic signed [PRIME_BITS+COEF_BITS:0] sprod, tprod;
  logic [COEF_BITS-1:0]         es0_mag, et0_mag;

  // multiplier lanes
  logic [WORD_BITS-1:0] a0, b0, m0, a1, b1, m1, res0, res1;
  logic [CNT_W-1:0]     nb;
  logic                 mm_op, mm_start, mm_done, mm_done1, single;
  logic [WORD_BITS:0]   rsum;
  logic [WORD_BITS-1:0] sdiff, ypr, yqr;

  always_comb begin
    a0 = WORD_BITS'(1);
    b0 = c_r;
    m0 = WORD_BITS'(p_r);
    a1 = WORD_BITS'(1);
    b1 = c_r;
    m1 = WORD_BITS'(q_r);
    nb = CNT_W'(WORD_BITS);
    case (cmd.op)
      OP_PMUL: begin
        a0 = WORD_BITS'(basep_r);
        b0 = {accp_r, {PRIME_BITS{1'b0}}};
        a1 = WORD_BITS'(baseq_r);
        b1 = {accq_r, {PRIME_BITS{1'b0}}};
        nb = CNT_W'(PRIME_BITS);
      end
      OP_PSQR: begin
        a0 = WORD_BITS'(basep_r);
        b0 = {basep_r, {PRIME_BITS{1'b0}}};
        a1 = WORD_BITS'(baseq_r);
        b1 = {baseq_r, {PRIME_BITS{1'b0}}};
        nb = CNT_W'(PRIME_BITS);
      end
      OP_YRED: begin
        b0 = vp_r;
        m0 = n_r;
        b1 = vq_r;
        m1 = n_r;
      end
      OP_TMUL: begin
        a0 = yp_r;
        b0 = {accq_r, {PRIME_BITS{1'b0}}};
        m0 = n_r;
        a1 = yq_r;
        b1 = {accp_r, {PRIME_BITS{1'b0}}};
        m1 = n_r;
        nb = CNT_W'(PRIME_BITS);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mm_op  = (cmd.op == OP_RED) || (cmd.op == OP_PMUL) || (cmd.op == OP_PSQR) ||
             (cmd.op == OP_YRED) || (cmd.op == OP_TMUL);
    single = (cmd.op == OP_LOAD) || (cmd.op == OP_PINIT) || (cmd.op == OP_EINIT) ||
             (cmd.op == OP_EUPD) || (cmd.op == OP_YMUL) || (cmd.op == OP_FIN1) ||
             (cmd.op == OP_FIN2);
  end

  assign mm_start = cmd.go && mm_op;

  rdfr_modmul u_lane_p (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .a(a0), .b(b0), .m(m0),
    .nbits(nb), .done(mm_done), .result(res0)
  );

  rdfr_modmul u_lane_q (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .a(a1), .b(b1), .m(m1),
    .nbits(nb), .done(mm_done1), .result(res1)
  );

  always_comb begin
    psum    = {1'b0, cfg_p_r} + (PRIME_BITS+1)'(1);
    qsum    = {1'b0, cfg_q_r} + (PRIME_BITS+1)'(1);
    dt      = {drem_r, dquo_r[PRIME_BITS-1]};
    dbit    = (dt >= {1'b0, er1_r});
    qs      = $signed({1'b0, dquo_r});
    sprod   = qs * es1_r;
    tprod   = qs * et1_r;
    es0_mag = es0_r[COEF_BITS-1] ? -es0_r : es0_r;
    et0_mag = et0_r[COEF_BITS-1] ? -et0_r : et0_r;
    ypr     = (negp_r && res0 != '0) ? n_r - res0 : res0;
    yqr     = (negq_r && res1 != '0) ? n_r - res1 : res1;
    rsum    = {1'b0, t1_r} + {1'b0, t2_r};
    sdiff   = t1_r - t2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_p_r     <= PRIME_BITS'(3);
      cfg_q_r     <= PRIME_BITS'(7);
      out_valid_r <= 1'b0;
      div_busy_r  <= 1'b0;
      div_done_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_PRIME_P) cfg_p_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_PRIME_Q) cfg_q_r <= cfg_data;
      if (cmd.go && cmd.op == OP_FIN2) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      div_done_r <= 1'b0;
      if (cmd.go && cmd.op == OP_EDIV) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && dcnt_r == CNT_W'(1)) begin
        div_busy_r <= 1'b0;
        div_done_r <= 1'b1;
      end
    end
  end

  // restoring divider for the Euclid quotient and remainder
  always_ff @(posedge clk) begin
    if (cmd.go && cmd.op == OP_EDIV) begin
      drem_r <= '0;
      dquo_r <= er0_r;
      dcnt_r <= CNT_W'(PRIME_BITS);
    end else if (div_busy_r) begin
      drem_r <= dbit ? PRIME_BITS'(dt - {1'b0, er1_r}) : dt[PRIME_BITS-1:0];
      dquo_r <= {dquo_r[PRIME_BITS-2:0], dbit};
      dcnt_r <= dcnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      case (cmd.op)
        OP_LOAD: begin
          c_r    <= in_ciphertext;
          p_r    <= cfg_p_r;
          q_r    <= cfg_q_r;
          n_r    <= WORD_BITS'(cfg_p_r) * WORD_BITS'(cfg_q_r);
          ep_r   <= PRIME_BITS'(psum[PRIME_BITS:2]);
          eq_r   <= PRIME_BITS'(qsum[PRIME_BITS:2]);
          zero_r <= (cfg_p_r == '0) || (cfg_q_r == '0);
        end
        OP_PINIT: begin
          accp_r  <= (p_r == PRIME_BITS'(1)) ? '0 : PRIME_BITS'(1);
          accq_r  <= (q_r == PRIME_BITS'(1)) ? '0 : PRIME_BITS'(1);
          round_r <= '0;
        end
        OP_EINIT: begin
          er0_r <= p_r;
          er1_r <= q_r;
          es0_r <= COEF_BITS'(1);
          es1_r <= '0;
          et0_r <= '0;
          et1_r <= COEF_BITS'(1);
        end
        OP_EUPD: begin
          er0_r <= er1_r;
          er1_r <= drem_r;
          es0_r <= es1_r;
          es1_r <= es0_r - sprod[COEF_BITS-1:0];
          et0_r <= et1_r;
          et1_r <= et0_r - tprod[COEF_BITS-1:0];
        end
        OP_YMUL: begin
          vp_r   <= WORD_BITS'(es0_mag[COEF_BITS-2:0]) * WORD_BITS'(p_r);
          vq_r   <= WORD_BITS'(et0_mag[COEF_BITS-2:0]) * WORD_BITS'(q_r);
          negp_r <= es0_r[COEF_BITS-1];
          negq_r <= et0_r[COEF_BITS-1];
        end
        OP_FIN1: begin
          r_r <= (rsum >= {1'b0, n_r}) ? WORD_BITS'(rsum - {1'b0, n_r}) : rsum[WORD_BITS-1:0];
          s_r <= (t1_r >= t2_r) ? sdiff : sdiff + n_r;
        end
        OP_FIN2: begin
          out_root_sum      <= zero_r ? '0 : r_r;
          out_root_sum_neg  <= (zero_r || r_r == '0) ? '0 : n_r - r_r;
          out_root_diff     <= zero_r ? '0 : s_r;
          out_root_diff_neg <= (zero_r || s_r == '0) ? '0 : n_r - s_r;
        end
        default: begin
        end
      endcase
    end
    if (mm_done) begin
      case (cmd.op)
        OP_RED: begin
          basep_r <= res0[PRIME_BITS-1:0];
          baseq_r <= res1[PRIME_BITS-1:0];
        end
        OP_PMUL: begin
          if (ep_r[0]) accp_r <= res0[PRIME_BITS-1:0];
          if (eq_r[0]) accq_r <= res1[PRIME_BITS-1:0];
        end
        OP_PSQR: begin
          basep_r <= res0[PRIME_BITS-1:0];
          baseq_r <= res1[PRIME_BITS-1:0];
          ep_r    <= ep_r >> 1;
          eq_r    <= eq_r >> 1;
          round_r <= round_r + ROUND_W'(1);
        end
        OP_YRED: begin
          yp_r <= ypr;
          yq_r <= yqr;
        end
        OP_TMUL: begin
          t1_r <= res0;
          t2_r <= res1;
        end
        default: begin
        end
      endcase
    end
  end

  // both lanes run the same bit count and finish together
  always_comb begin
    stat.done       = (cmd.go && single) || (mm_done && mm_done1) || div_done_r;
    stat.zero_prime = (cfg_p_r == '0) || (cfg_q_r == '0);
    stat.last_round = (round_r == ROUND_W'(PRIME_BITS - 1));
    stat.eu_done    = (er1_r == '0);
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/rabin_decrypt_four_roots_unit.sv
// Latency and throughput depend on k, the number of Euclid quotient steps (at most 24
// for 16-bit primes); a zero prime goes straight to the output step.
// A new item is taken in only after the current one has been written to the output register.
// A finished item waits in the output register while the next item is taken in.
// Reset (rst_n low, synchronous): controller idle, output empty, p = 3, q = 7.
// Top level: Rabin decryption returning the four square roots modulo p*q.
module rabin_decrypt_four_roots_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_ciphertext,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_root_sum,
  output logic [31:0] out_root_sum_neg,
  output logic [31:0] out_root_diff,
  output logic [31:0] out_root_diff_neg
);
  import rdfr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rdfr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  rdfr_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ciphertext(in_ciphertext), .cmd(cmd), .stat(stat),
    .out_ready(out_ready), .out_valid(out_valid), .out_root_sum(out_root_sum),
    .out_root_sum_neg(out_root_sum_neg), .out_root_diff(out_root_diff),
    .out_root_diff_neg(out_root_diff_neg)
  );

endmodule

// File: rtl/rdfr_checker.sv
// Port-level checks for the Rabin decryption unit, bound to the top level.
module rdfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_root_sum,
  input logic [31:0] out_root_sum_neg,
  input logic [31:0] out_root_diff,
  input logic [31:0] out_root_diff_neg
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_root_sum) &&
    $stable(out_root_sum_neg) && $stable(out_root_diff) && $stable(out_root_diff_neg))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before item finished");

  a_sum_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_root_sum == 32'd0) == (out_root_sum_neg == 32'd0)))
    else $error("root sum and its negation disagree on zero");

  a_diff_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_root_diff == 32'd0) == (out_root_diff_neg == 32'd0)))
    else $error("root difference and its negation disagree on zero");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("unit not idle after reset");

endmodule

bind rabin_decrypt_four_roots_unit rdfr_checker u_rdfr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_root_sum(out_root_sum),
  .out_root_sum_neg(out_root_sum_neg), .out_root_diff(out_root_diff),
  .out_root_diff_neg(out_root_diff_neg)
);
